@@ hw/rtl/cdrt_pkg.sv @@
package cdrt_pkg;

  // Default sizing, handed to the top-level parameters.
  localparam int DEF_SLOTS_PER_CHUNK = 32;
  localparam int DEF_MAX_CHUNKS      = 16;
  localparam int DEF_HEADER_BYTES    = 8;

  // Per-slot reception count saturates here.
  localparam logic [6:0] SLOT_COUNT_MAX = 7'd127;

  typedef enum logic [1:0] {
    OUTC_NEW   = 2'd0,
    OUTC_DUP   = 2'd1,
    OUTC_SHORT = 2'd2,
    OUTC_BAD   = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_UPDATE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_FINISH,
    ST_OUTPUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic check;
    logic update;
    logic scan_rd;
    logic scan_ev;
    logic finish;
    logic load_out;
    logic clear_step;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_short;
    logic is_bad;
    logic need_scan;
    logic scan_end;
    logic scan_hit;
    logic clr_last;
    logic out_free;
    logic ddone;
  } status_t;

endpackage

@@ hw/rtl/cdrt_ctrl.sv @@
module cdrt_ctrl
  import cdrt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  status_t status,
  output cmd_t    cmd,
  output logic    in_stall
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.is_short || status.is_bad) state_nxt = ST_OUTPUT;
        else state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (status.need_scan) state_nxt = ST_SCAN_RD;
        else state_nxt = ST_OUTPUT;
      end
      ST_SCAN_RD: begin
        if (status.scan_end) state_nxt = ST_FINISH;
        else state_nxt = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        if (status.scan_hit) state_nxt = ST_SCAN_RD;
        else state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        state_nxt = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (status.out_free) begin
          if (status.ddone) state_nxt = ST_CLEAR;
          else state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_CLEAR:   cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_CHECK:   cmd.check    = 1'b1;
      ST_UPDATE:  cmd.update   = 1'b1;
      ST_SCAN_RD: cmd.scan_rd  = ~status.scan_end;
      ST_SCAN_EV: cmd.scan_ev  = 1'b1;
      ST_FINISH:  cmd.finish   = 1'b1;
      ST_OUTPUT:  cmd.load_out = status.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hw/rtl/cdrt_dpath.sv @@
module cdrt_dpath
  import cdrt_pkg::*;
#(
  parameter int SLOTS_PER_CHUNK = DEF_SLOTS_PER_CHUNK,
  parameter int MAX_CHUNKS      = DEF_MAX_CHUNKS,
  parameter int HEADER_BYTES    = DEF_HEADER_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [7:0]  in_chunk_index,
  input  logic [7:0]  in_slot_seq,
  input  logic [31:0] in_chunk_length,
  input  logic [7:0]  in_chunks_total,
  input  logic [7:0]  in_packet_len,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [1:0]  out_outcome,
  output logic        out_chunk_done,
  output logic        out_download_done,
  output logic [31:0] out_packets_total,
  output logic [15:0] out_packets_distinct,
  output logic [31:0] out_bytes_received,
  output logic [31:0] out_corrupt_count,
  output logic        out_download_active
);

  localparam int DEPTH = MAX_CHUNKS * SLOTS_PER_CHUNK;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int FW    = $clog2(SLOTS_PER_CHUNK + 1);
  localparam int NW    = $clog2(MAX_CHUNKS + 1);

  localparam logic [8:0]  MAX_C   = 9'(MAX_CHUNKS);
  localparam logic [8:0]  SLOTS_C = 9'(SLOTS_PER_CHUNK);
  localparam logic [FW-1:0] FILL_FULL = FW'(SLOTS_PER_CHUNK);
  localparam logic [7:0]  HDR_C   = 8'(HEADER_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  // Captured word
  logic [7:0] chunk_r, seq_r, ctot_r, plen_r;
  logic       clen_neg_r;

  // Memories: per-slot counts, per-chunk fill counts
  logic [6:0]    slot_mem [DEPTH];
  logic [FW-1:0] fill_mem [MAX_CHUNKS];
  logic [6:0]    slot_rdata_r;
  logic [FW-1:0] fill_rdata_r;

  // Download state
  logic          active_r, active_nxt;
  logic [NW-1:0] announced_r, announced_nxt;
  logic [NW-1:0] prefix_r, prefix_nxt;
  logic [31:0]   total_r, total_nxt;
  logic [15:0]   distinct_r, distinct_nxt;
  logic [31:0]   bytes_r, bytes_nxt;
  logic [31:0]   corrupt_r, corrupt_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // Result in progress
  logic [1:0] outcome_r, outcome_nxt;
  logic       cdone_r, cdone_nxt;
  logic       ddone_r, ddone_nxt;

  // Output register
  logic        ovalid_r, ovalid_nxt;
  logic [1:0]  o_outcome_r;
  logic        o_cdone_r, o_ddone_r, o_active_r;
  logic [31:0] o_total_r, o_bytes_r, o_corrupt_r;
  logic [15:0] o_distinct_r;

  logic          is_short, is_bad, is_new, cdone_now, need_scan;
  logic [16:0]   addr_full;
  logic [AW-1:0] slot_addr;
  logic [CAW-1:0] fill_raddr;
  logic [7:0]    pay;
  logic [32:0]   bytes_sum;
  logic [FW-1:0] fill_inc;
  logic          slot_we, fill_we;
  logic [AW-1:0] slot_waddr;
  logic [6:0]    slot_wdata;
  logic [CAW-1:0] fill_waddr;
  logic [FW-1:0] fill_wdata;
  logic          out_free;

  always_comb begin
    is_short  = plen_r < HDR_C;
    is_bad    = ({1'b0, seq_r} >= SLOTS_C) || ({1'b0, chunk_r} >= MAX_C) || clen_neg_r;
    addr_full = 17'(chunk_r) * 17'(SLOTS_PER_CHUNK) + 17'(seq_r);
    slot_addr = addr_full[AW-1:0];
    is_new    = (slot_rdata_r == 7'd0);
    fill_inc  = fill_rdata_r + FW'(1);
    cdone_now = (fill_inc == FILL_FULL);
    need_scan = is_new && cdone_now && (9'(chunk_r) == 9'(prefix_r));
    pay       = plen_r - HDR_C;
    bytes_sum = {1'b0, bytes_r} + 33'(pay);
    out_free  = ~ovalid_r | ~out_stall;
    fill_raddr = cmd.scan_rd ? prefix_r[CAW-1:0] : chunk_r[CAW-1:0];
  end

  always_comb begin
    status.is_short  = is_short;
    status.is_bad    = is_bad;
    status.need_scan = need_scan;
    status.scan_end  = (9'(prefix_r) == MAX_C);
    status.scan_hit  = (fill_rdata_r == FILL_FULL);
    status.clr_last  = (clr_cnt_r == CLR_LAST);
    status.out_free  = out_free;
    status.ddone     = ddone_r;
  end

  // Memory write selection: clearing sweep or update
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = slot_addr;
    slot_wdata = slot_rdata_r + 7'd1;
    fill_we    = 1'b0;
    fill_waddr = chunk_r[CAW-1:0];
    fill_wdata = fill_inc;
    if (cmd.clear_step) begin
      slot_we    = 1'b1;
      slot_waddr = clr_cnt_r;
      slot_wdata = 7'd0;
      fill_we    = (17'(clr_cnt_r) < 17'(MAX_CHUNKS));
      fill_waddr = clr_cnt_r[CAW-1:0];
      fill_wdata = '0;
    end else if (cmd.update) begin
      slot_we = (slot_rdata_r != SLOT_COUNT_MAX);
      fill_we = is_new;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (cmd.check) slot_rdata_r <= slot_mem[slot_addr];
  end

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    if (cmd.check || cmd.scan_rd) fill_rdata_r <= fill_mem[fill_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      chunk_r    <= in_chunk_index;
      seq_r      <= in_slot_seq;
      clen_neg_r <= in_chunk_length[31];
      ctot_r     <= in_chunks_total;
      plen_r     <= in_packet_len;
    end
  end

  always_comb begin
    active_nxt    = active_r;
    announced_nxt = announced_r;
    prefix_nxt    = prefix_r;
    total_nxt     = total_r;
    distinct_nxt  = distinct_r;
    bytes_nxt     = bytes_r;
    corrupt_nxt   = corrupt_r;
    outcome_nxt   = outcome_r;
    cdone_nxt     = cdone_r;
    ddone_nxt     = ddone_r;
    clr_cnt_nxt   = clr_cnt_r;

    if (cmd.clear_step) begin
      clr_cnt_nxt = (clr_cnt_r == CLR_LAST) ? '0 : clr_cnt_r + AW'(1);
    end

    if (cmd.check) begin
      cdone_nxt = 1'b0;
      ddone_nxt = 1'b0;
      if (is_short) begin
        outcome_nxt = OUTC_SHORT;
        if (plen_r != 8'd0 && corrupt_r != 32'hFFFF_FFFF) corrupt_nxt = corrupt_r + 32'd1;
      end else if (is_bad) begin
        outcome_nxt = OUTC_BAD;
      end
    end

    if (cmd.update) begin
      active_nxt    = 1'b1;
      announced_nxt = ({1'b0, ctot_r} > MAX_C) ? NW'(MAX_CHUNKS) : NW'(ctot_r);
      if (total_r != 32'hFFFF_FFFF) total_nxt = total_r + 32'd1;
      if (!is_new) begin
        outcome_nxt = OUTC_DUP;
      end else begin
        outcome_nxt = OUTC_NEW;
        cdone_nxt   = cdone_now;
        if (distinct_r != 16'hFFFF) distinct_nxt = distinct_r + 16'd1;
        bytes_nxt = bytes_sum[32] ? 32'hFFFF_FFFF : bytes_sum[31:0];
        if (need_scan) begin
          prefix_nxt = prefix_r + NW'(1);
        end else begin
          ddone_nxt = (9'(prefix_r) >= 9'(announced_nxt));
        end
      end
    end

    if (cmd.scan_ev && status.scan_hit) prefix_nxt = prefix_r + NW'(1);

    if (cmd.finish) ddone_nxt = (9'(prefix_r) >= 9'(announced_r));

    // Download complete: result takes the final counts, then everything clears.
    if (cmd.load_out && ddone_r) begin
      active_nxt    = 1'b0;
      announced_nxt = '0;
      prefix_nxt    = '0;
      total_nxt     = '0;
      distinct_nxt  = '0;
      bytes_nxt     = '0;
      corrupt_nxt   = '0;
    end
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.load_out) ovalid_nxt = 1'b1;
    else if (~out_stall) ovalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      announced_r <= '0;
      prefix_r    <= '0;
      total_r     <= '0;
      distinct_r  <= '0;
      bytes_r     <= '0;
      corrupt_r   <= '0;
      clr_cnt_r   <= '0;
      outcome_r   <= OUTC_NEW;
      cdone_r     <= 1'b0;
      ddone_r     <= 1'b0;
      ovalid_r    <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      announced_r <= announced_nxt;
      prefix_r    <= prefix_nxt;
      total_r     <= total_nxt;
      distinct_r  <= distinct_nxt;
      bytes_r     <= bytes_nxt;
      corrupt_r   <= corrupt_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      outcome_r   <= outcome_nxt;
      cdone_r     <= cdone_nxt;
      ddone_r     <= ddone_nxt;
      ovalid_r    <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_outcome_r  <= outcome_r;
      o_cdone_r    <= cdone_r;
      o_ddone_r    <= ddone_r;
      o_total_r    <= total_r;
      o_distinct_r <= distinct_r;
      o_bytes_r    <= bytes_r;
      o_corrupt_r  <= corrupt_r;
      o_active_r   <= active_r & ~ddone_r;
    end
  end

  assign out_valid            = ovalid_r;
  assign out_outcome          = o_outcome_r;
  assign out_chunk_done       = o_cdone_r;
  assign out_download_done    = o_ddone_r;
  assign out_packets_total    = o_total_r;
  assign out_packets_distinct = o_distinct_r;
  assign out_bytes_received   = o_bytes_r;
  assign out_corrupt_count    = o_corrupt_r;
  assign out_download_active  = o_active_r;

endmodule

@@ hw/rtl/chunked_download_reassembly_tracker_core.sv @@
// Channel  Direction  Handshake            Payload
// in_*     input      in_valid / in_stall  chunk_index, slot_seq, chunk_length,
//                                          chunks_total, packet_len
// out_*    output     out_valid/out_stall  outcome, chunk_done, download_done,
//                                          counters, download_active
//
// Each word steps through accept, classify + memory read, update and output load;
// a runt or bad header skips the update.
// A word that completes the lowest incomplete chunk walks the per-chunk fill
// memory one read port access at a time, past each further chunk already
// complete, until it meets an incomplete one or runs past the last chunk.
// Reset and download completion both start a clearing sweep of the slot memory
// over all MAX_CHUNKS*SLOTS_PER_CHUNK slots (512 by default), in_stall high.
// The output register frees the datapath: a held result stalls only the next
// output load, so one more word is accepted behind it before in_stall holds.
module chunked_download_reassembly_tracker_core
  import cdrt_pkg::*;
#(
  parameter int SLOTS_PER_CHUNK = DEF_SLOTS_PER_CHUNK,
  parameter int MAX_CHUNKS      = DEF_MAX_CHUNKS,
  parameter int HEADER_BYTES    = DEF_HEADER_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_chunk_index,
  input  logic [7:0]  in_slot_seq,
  input  logic [31:0] in_chunk_length,
  input  logic [7:0]  in_chunks_total,
  input  logic [7:0]  in_packet_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_outcome,
  output logic        out_chunk_done,
  output logic        out_download_done,
  output logic [31:0] out_packets_total,
  output logic [15:0] out_packets_distinct,
  output logic [31:0] out_bytes_received,
  output logic [31:0] out_corrupt_count,
  output logic        out_download_active
);

  // Controller sequences classify / update / scan / output;
  // datapath holds slot counts, chunk fill counts and download counters.
  cmd_t    cmd;
  status_t status;

  cdrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  cdrt_dpath #(
    .SLOTS_PER_CHUNK (SLOTS_PER_CHUNK),
    .MAX_CHUNKS      (MAX_CHUNKS),
    .HEADER_BYTES    (HEADER_BYTES)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_chunk_index       (in_chunk_index),
    .in_slot_seq          (in_slot_seq),
    .in_chunk_length      (in_chunk_length),
    .in_chunks_total      (in_chunks_total),
    .in_packet_len        (in_packet_len),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_outcome          (out_outcome),
    .out_chunk_done       (out_chunk_done),
    .out_download_done    (out_download_done),
    .out_packets_total    (out_packets_total),
    .out_packets_distinct (out_packets_distinct),
    .out_bytes_received   (out_bytes_received),
    .out_corrupt_count    (out_corrupt_count),
    .out_download_active  (out_download_active)
  );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import cdrt_pkg::*;

  // Sizing follows the package defaults; the block is instantiated with them.
  localparam int SLOTS  = DEF_SLOTS_PER_CHUNK;
  localparam int CHUNKS = DEF_MAX_CHUNKS;
  localparam int HDR    = DEF_HEADER_BYTES;
  localparam int NSLOT  = SLOTS * CHUNKS;

  // Clock and reset. Every block input holds a known value from time zero.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_chunk_index = '0;
  logic [7:0]  in_slot_seq = '0;
  logic [31:0] in_chunk_length = '0;
  logic [7:0]  in_chunks_total = '0;
  logic [7:0]  in_packet_len = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_outcome;
  logic        out_chunk_done;
  logic        out_download_done;
  logic [31:0] out_packets_total;
  logic [15:0] out_packets_distinct;
  logic [31:0] out_bytes_received;
  logic [31:0] out_corrupt_count;
  logic        out_download_active;

  // One status word as the block should report it.
  typedef struct {
    outcome_t    outcome;
    logic        chunk_done;
    logic        download_done;
    logic [31:0] packets_total;
    logic [15:0] packets_distinct;
    logic [31:0] bytes_received;
    logic [31:0] corrupt_count;
    logic        download_active;
  } report_t;

  // Expected status words, oldest first.
  report_t reports_due[$];
  int      mismatches = 0;

  // Idle and stall rates in percent; the test sequence changes them per phase.
  int idle_pct = 0;
  int stall_pct = 0;

  // Shadow copy of the tracker state.
  logic [6:0]  fill_cnt [NSLOT];
  logic        chunk_mark [CHUNKS];
  int          announced;
  logic        dl_active;
  logic [31:0] total_cnt;
  logic [15:0] distinct_cnt;
  logic [31:0] bytes_cnt;
  logic [31:0] corrupt_cnt;

  chunked_download_reassembly_tracker_core DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_chunk_index       (in_chunk_index),
    .in_slot_seq          (in_slot_seq),
    .in_chunk_length      (in_chunk_length),
    .in_chunks_total      (in_chunks_total),
    .in_packet_len        (in_packet_len),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_outcome          (out_outcome),
    .out_chunk_done       (out_chunk_done),
    .out_download_done    (out_download_done),
    .out_packets_total    (out_packets_total),
    .out_packets_distinct (out_packets_distinct),
    .out_bytes_received   (out_bytes_received),
    .out_corrupt_count    (out_corrupt_count),
    .out_download_active  (out_download_active)
  );

  always #6 clk = ~clk;

  // Receiver back-pressure: redrawn every falling edge, stable at the rising one.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Wipes every slot count, chunk mark and counter; reset and download
  // completion both land here.
  function automatic void clear_tracker();
    foreach (fill_cnt[i]) fill_cnt[i] = '0;
    foreach (chunk_mark[i]) chunk_mark[i] = 1'b0;
    announced = 0;
    dl_active = 1'b0;
    total_cnt = '0;
    distinct_cnt = '0;
    bytes_cnt = '0;
    corrupt_cnt = '0;
  endfunction

  // Classifies one packet header against the shadow state, updates that state
  // and returns the status word the block must produce for it.
  function automatic report_t track_packet(logic [7:0] chunk, logic [7:0] seq,
                                           logic [31:0] clen, logic [7:0] ctot,
                                           logic [7:0] plen);
    report_t     r;
    int          idx;
    int          i;
    logic [6:0]  prev;
    logic [32:0] sum;
    logic        full;
    r.outcome = OUTC_SHORT;
    r.chunk_done = 1'b0;
    r.download_done = 1'b0;
    if (plen < HDR) begin
      // Runt: only a nonempty one counts as corrupt, nothing else moves.
      if (plen != 0 && corrupt_cnt != '1) corrupt_cnt++;
    end else if (seq >= SLOTS || chunk >= CHUNKS || clen[31]) begin
      r.outcome = OUTC_BAD;
    end else begin
      idx = chunk * SLOTS + seq;
      prev = fill_cnt[idx];
      dl_active = 1'b1;
      announced = (ctot > CHUNKS) ? CHUNKS : ctot;
      if (total_cnt != '1) total_cnt++;
      if (prev != SLOT_COUNT_MAX) fill_cnt[idx] = prev + 7'd1;
      if (prev != 0) begin
        r.outcome = OUTC_DUP;
      end else begin
        r.outcome = OUTC_NEW;
        if (distinct_cnt != '1) distinct_cnt++;
        sum = 33'(bytes_cnt) + 33'(plen) - 33'(HDR);
        bytes_cnt = sum[32] ? '1 : sum[31:0];
        full = 1'b1;
        for (i = 0; i < SLOTS; i++) begin
          if (fill_cnt[chunk * SLOTS + i] == 0) full = 1'b0;
        end
        if (full) begin
          r.chunk_done = 1'b1;
          chunk_mark[chunk] = 1'b1;
        end
        // With zero chunks announced this loop is empty: any new word finishes.
        r.download_done = 1'b1;
        for (i = 0; i < announced; i++) begin
          if (!chunk_mark[i]) r.download_done = 1'b0;
        end
      end
    end
    r.packets_total = total_cnt;
    r.packets_distinct = distinct_cnt;
    r.bytes_received = bytes_cnt;
    r.corrupt_count = corrupt_cnt;
    r.download_active = r.download_done ? 1'b0 : dl_active;
    // Counters above already show the finishing word; then everything clears.
    if (r.download_done) clear_tracker();
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  // Result side: each accepted status word is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (reports_due.size() == 0) begin
        mismatches++;
        $display("%0t ns: status word with none expected, outcome %0d",
                 $time, out_outcome);
      end else begin
        want = reports_due.pop_front();
        check_field("outcome", 32'(want.outcome), 32'(out_outcome));
        check_field("chunk_done", 32'(want.chunk_done), 32'(out_chunk_done));
        check_field("download_done", 32'(want.download_done), 32'(out_download_done));
        check_field("packets_total", want.packets_total, out_packets_total);
        check_field("packets_distinct", 32'(want.packets_distinct),
                    32'(out_packets_distinct));
        check_field("bytes_received", want.bytes_received, out_bytes_received);
        check_field("corrupt_count", want.corrupt_count, out_corrupt_count);
        check_field("download_active", 32'(want.download_active),
                    32'(out_download_active));
      end
    end
  end

  // Sends one word. Called at a falling edge, returns at a falling edge with
  // in_valid still high, so back-to-back words never drop valid.
  task automatic send_word(input logic [7:0] chunk, input logic [7:0] seq,
                           input logic [31:0] clen, input logic [7:0] ctot,
                           input logic [7:0] plen);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_chunk_index <= chunk;
    in_slot_seq <= seq;
    in_chunk_length <= clen;
    in_chunks_total <= ctot;
    in_packet_len <= plen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    reports_due.push_back(track_packet(chunk, seq, clen, ctot, plen));
    @(negedge clk);
  endtask

  // Sender holds off until every outstanding status word has been checked.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
  endtask

  // One background word: mostly well-formed, some runts, bad headers and
  // fully random fields so every input bit toggles.
  task automatic send_noise();
    logic [7:0]  c, s, t, p;
    logic [31:0] l;
    int          kind;
    int          pick;
    c = 8'($urandom_range(CHUNKS - 1));
    s = 8'($urandom_range(SLOTS - 1));
    l = $urandom();
    l[31] = 1'b0;
    pick = $urandom_range(99);
    if (pick < 8) t = 8'd0;
    else if (pick < 20) t = 8'($urandom_range(255, CHUNKS));
    else t = 8'($urandom_range(4, 1));
    p = 8'($urandom_range(255, HDR));
    kind = $urandom_range(99);
    if (kind < 20) begin
      p = 8'($urandom_range(HDR - 1));
    end else if (kind < 27) begin
      c = 8'($urandom_range(255, CHUNKS));
    end else if (kind < 34) begin
      s = 8'($urandom_range(255, SLOTS));
    end else if (kind < 40) begin
      l[31] = 1'b1;
    end else if (kind < 50) begin
      c = 8'($urandom());
      s = 8'($urandom());
      l = $urandom();
      t = 8'($urandom());
      p = 8'($urandom());
    end
    send_word(c, s, l, t, p);
  endtask

  // Well-formed download: every slot of chunks 0..n-1 in random order, maybe
  // one extra unannounced chunk, with duplicates and background noise mixed in.
  task automatic run_download(input int n_chunks, input int noise_pct);
    int          slots[$];
    int          k, j, tmp, c, extra;
    logic [31:0] l;
    for (c = 0; c < n_chunks; c++) begin
      for (j = 0; j < SLOTS; j++) slots.push_back(c * SLOTS + j);
    end
    if ($urandom_range(99) < 30 && n_chunks < CHUNKS) begin
      extra = $urandom_range(CHUNKS - 1, n_chunks);
      for (j = 0; j < SLOTS; j++) slots.push_back(extra * SLOTS + j);
    end
    for (k = slots.size() - 1; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = slots[k];
      slots[k] = slots[j];
      slots[j] = tmp;
    end
    for (k = 0; k < slots.size(); k++) begin
      if ($urandom_range(99) < noise_pct) send_noise();
      l = $urandom();
      l[31] = 1'b0;
      if (k > 0 && $urandom_range(99) < 10) begin
        j = slots[$urandom_range(k - 1)];
        send_word(8'(j / SLOTS), 8'(j % SLOTS), l, 8'(n_chunks),
                  8'($urandom_range(255, HDR)));
      end
      send_word(8'(slots[k] / SLOTS), 8'(slots[k] % SLOTS), l, 8'(n_chunks),
                8'($urandom_range(255, HDR)));
    end
  endtask

  // Classification corners: runt lengths, every kind of bad header, length
  // and count extremes, duplicates, and completion with zero chunks announced.
  task automatic test_header_checks();
    send_word(8'd0, 8'd0, 32'd0, 8'd1, 8'd0);               // empty runt, not corrupt
    send_word(8'd0, 8'd0, 32'd0, 8'd1, 8'd1);               // runt, corrupt
    send_word(8'd255, 8'd255, 32'hFFFF_FFFF, 8'd255, 8'd7); // runt wins over bad header
    send_word(8'd16, 8'd0, 32'd0, 8'd1, 8'd8);              // chunk just past range
    send_word(8'd255, 8'd0, 32'd0, 8'd1, 8'd8);
    send_word(8'd0, 8'd32, 32'd0, 8'd1, 8'd8);              // slot just past range
    send_word(8'd0, 8'd255, 32'd0, 8'd1, 8'd8);
    send_word(8'd0, 8'd0, 32'h8000_0000, 8'd1, 8'd8);       // negative chunk length
    send_word(8'd0, 8'd0, 32'hFFFF_FFFF, 8'd1, 8'd8);
    send_word(8'd0, 8'd0, 32'h7FFF_FFFF, 8'd2, 8'd8);       // first word, empty payload
    send_word(8'd0, 8'd0, 32'h7FFF_FFFF, 8'd2, 8'd8);       // duplicate
    send_word(8'd15, 8'd31, 32'd0, 8'd255, 8'd255);         // top slot, announced total clamps
    send_word(8'd15, 8'd31, 32'd5, 8'd255, 8'd100);
    send_word(8'd1, 8'd1, 32'd0, 8'd2, 8'd7);               // runt mid-download
    send_word(8'd3, 8'd4, 32'd9, 8'd0, 8'd20);              // zero announced: done
    send_word(8'd0, 8'd0, 32'd0, 8'd1, 8'd9);               // state was cleared: new
    send_word(8'd0, 8'd0, 32'd0, 8'd0, 8'd9);               // duplicate never finishes
    send_word(8'd0, 8'd1, 32'd0, 8'd0, 8'd9);               // new word finishes
  endtask

  // Hammer one slot past its 7-bit count limit; it must keep reading as seen.
  task automatic test_slot_saturation();
    repeat (132) send_word(8'd9, 8'd17, 32'd64, 8'd5, 8'($urandom_range(255, HDR)));
    send_word(8'd9, 8'd18, 32'd64, 8'd5, 8'd12);
  endtask

  // One- and two-chunk downloads, each maybe with a chunk outside the announced range.
  task automatic test_chunk_completion();
    run_download(1, 0);
    run_download(2, 0);
  endtask

  task automatic test_traffic_phase(input int pin, input int pout);
    idle_pct = pin;
    stall_pct = pout;
    repeat (3) run_download($urandom_range(3, 1), 10);
    repeat (60) send_noise();
    wait_drain();
  endtask

  initial begin
    clear_tracker();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_header_checks();
    wait_drain();
    test_slot_saturation();
    test_chunk_completion();
    wait_drain();
    test_traffic_phase(0, 0);
    test_traffic_phase(78, 0);
    test_traffic_phase(0, 78);
    test_traffic_phase(15, 15);

    wait_drain();
    repeat (40) @(negedge clk);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hang guard, far above the slowest correct run including clearing sweeps.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
